// ===== hw/rtl/i2cm_pkg.sv =====
// Shared types, codes and plan table for the I2C master register access block.
package i2cm_pkg;

    localparam int PHASE_BITS = 16;
    localparam int POLL_BITS  = 8;
    localparam int CFG_IDX_BITS = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_TICKS = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACK_POLLS   = 1'd1;

    localparam logic [PHASE_BITS-1:0] PHASE_TICKS_RST = 16'd2;
    localparam logic [POLL_BITS-1:0]  ACK_POLLS_RST   = 8'd250;

    // Command modes
    localparam logic [2:0] MODE_START     = 3'd0;
    localparam logic [2:0] MODE_STOP      = 3'd1;
    localparam logic [2:0] MODE_WRITE     = 3'd2;
    localparam logic [2:0] MODE_READ      = 3'd3;
    localparam logic [2:0] MODE_REG_WRITE = 3'd4;
    localparam logic [2:0] MODE_REG_READ  = 3'd5;

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_S_PRE = 4'd1;
    localparam logic [3:0] ST_S_H1  = 4'd2;
    localparam logic [3:0] ST_S_H2  = 4'd3;
    localparam logic [3:0] ST_S_L1  = 4'd4;
    localparam logic [3:0] ST_S_L2  = 4'd5;
    localparam logic [3:0] ST_P_L   = 4'd6;
    localparam logic [3:0] ST_P_H1  = 4'd7;
    localparam logic [3:0] ST_P_H2  = 4'd8;
    localparam logic [3:0] ST_P_R1  = 4'd9;
    localparam logic [3:0] ST_P_R2  = 4'd10;
    localparam logic [3:0] ST_T_LO  = 4'd11;
    localparam logic [3:0] ST_T_HI  = 4'd12;
    localparam logic [3:0] ST_POLL  = 4'd13;
    localparam logic [3:0] ST_R_LO  = 4'd14;
    localparam logic [3:0] ST_R_HI  = 4'd15;

    // Bus segment kinds
    localparam logic [2:0] SEG_NONE  = 3'd0;
    localparam logic [2:0] SEG_START = 3'd1;
    localparam logic [2:0] SEG_STOP  = 3'd2;
    localparam logic [2:0] SEG_TX    = 3'd3;
    localparam logic [2:0] SEG_RX    = 3'd4;

    localparam logic [7:0] RW_READ_BIT = 8'h01;
    localparam logic [7:0] RW_WRITE_MASK = 8'hFE;

    typedef struct packed {
        logic       command_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic       sda_sampled;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_result;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } t_plan;

    // One entry of a command's segment plan
    function automatic t_plan plan_entry(input logic [2:0] mode, input logic [2:0] idx,
                                         input logic [7:0] dev, input logic [7:0] reg_addr,
                                         input logic [7:0] data);
        t_plan p;
        p.kind = SEG_NONE;
        p.data = 8'd0;
        case (mode)
            MODE_START: if (idx == 3'd0) p.kind = SEG_START;
            MODE_STOP:  if (idx == 3'd0) p.kind = SEG_STOP;
            MODE_WRITE: begin
                p.data = data;
                if (idx == 3'd0) p.kind = SEG_TX;
            end
            MODE_READ:  if (idx == 3'd0) p.kind = SEG_RX;
            MODE_REG_WRITE: begin
                case (idx)
                    3'd0: p.kind = SEG_START;
                    3'd1: begin p.kind = SEG_TX; p.data = dev & RW_WRITE_MASK; end
                    3'd2: begin p.kind = SEG_TX; p.data = reg_addr; end
                    3'd3: begin p.kind = SEG_TX; p.data = data; end
                    3'd4: p.kind = SEG_STOP;
                    default: p.kind = SEG_NONE;
                endcase
            end
            MODE_REG_READ: begin
                case (idx)
                    3'd0: p.kind = SEG_START;
                    3'd1: begin p.kind = SEG_TX; p.data = dev & RW_WRITE_MASK; end
                    3'd2: begin p.kind = SEG_TX; p.data = reg_addr; end
                    3'd3: p.kind = SEG_START;
                    3'd4: begin p.kind = SEG_TX; p.data = dev | RW_READ_BIT; end
                    3'd5: p.kind = SEG_RX;
                    3'd6: p.kind = SEG_STOP;
                    default: p.kind = SEG_NONE;
                endcase
            end
            default: p.kind = SEG_NONE;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] seg_first_state(input logic [2:0] kind);
        logic [3:0] s;
        case (kind)
            SEG_START: s = ST_S_PRE;
            SEG_STOP:  s = ST_P_L;
            SEG_TX:    s = ST_T_LO;
            default:   s = ST_R_LO;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/i2cm_engine.sv =====
// Bit sequencer: one tick of bus timing per step, state held in registers.
module i2cm_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  i2cm_pkg::t_item                 i_item,
    input  logic [i2cm_pkg::PHASE_BITS-1:0] i_phase_ticks,
    input  logic [i2cm_pkg::POLL_BITS-1:0]  i_ack_polls,
    output i2cm_pkg::t_result               o_res
);

    logic [3:0]                      r_state, n_state;
    logic [i2cm_pkg::PHASE_BITS-1:0] r_phase, n_phase;
    logic [3:0]                      r_bit, n_bit;
    logic [7:0]                      r_shift, n_shift;
    logic [2:0]                      r_step, n_step;
    logic [i2cm_pkg::POLL_BITS-1:0]  r_wait, n_wait;
    logic                            r_err, n_err;
    logic [7:0]                      r_rx, n_rx;
    logic [2:0]                      r_mode, n_mode;
    logic [7:0]                      r_dev, n_dev;
    logic [7:0]                      r_reg, n_reg;
    logic [7:0]                      r_data, n_data;
    logic                            r_ack, n_ack;
    logic                            r_stop_ins, n_stop_ins;
    logic                            r_line_scl, n_line_scl;
    logic                            r_line_sda, n_line_sda;

    logic [i2cm_pkg::PHASE_BITS-1:0] w_plen;
    logic [i2cm_pkg::POLL_BITS-1:0]  w_limit;

    assign w_plen  = (i_phase_ticks == '0) ? {{(i2cm_pkg::PHASE_BITS-1){1'b0}}, 1'b1}
                                           : i_phase_ticks;
    assign w_limit = (i_ack_polls == '0) ? {{(i2cm_pkg::POLL_BITS-1){1'b0}}, 1'b1}
                                         : i_ack_polls;

    always_comb begin
        i2cm_pkg::t_plan acc_plan;
        i2cm_pkg::t_plan nxt_plan;
        logic            scl;
        logic            sda;
        logic            busy;
        logic            done;
        logic            seg_end;
        logic            was_stop;
        logic            fin;
        logic            after_stop;
        logic [2:0]      idx;
        logic [7:0]      rx_shift;

        n_state = r_state;   n_phase = r_phase;   n_bit = r_bit;
        n_shift = r_shift;   n_step = r_step;     n_wait = r_wait;
        n_err = r_err;       n_rx = r_rx;         n_mode = r_mode;
        n_dev = r_dev;       n_reg = r_reg;       n_data = r_data;
        n_ack = r_ack;       n_stop_ins = r_stop_ins;
        n_line_scl = r_line_scl;
        n_line_sda = r_line_sda;
        acc_plan = '0;
        nxt_plan = '0;
        scl = r_line_scl;
        sda = r_line_sda;
        busy = 1'b0;
        done = 1'b0;
        seg_end = 1'b0;
        was_stop = 1'b0;
        fin = 1'b0;
        after_stop = 1'b0;
        idx = 3'd0;
        rx_shift = 8'd0;

        // New command, taken only when idle and for a known mode
        if (r_state == i2cm_pkg::ST_IDLE && i_item.command_valid &&
            i_item.mode <= i2cm_pkg::MODE_REG_READ) begin
            n_mode = i_item.mode;
            n_data = i_item.tx_byte;
            n_ack  = i_item.send_ack;
            n_dev  = i_item.device_address;
            n_reg  = i_item.register_address;
            n_stop_ins = 1'b0;
            n_err  = 1'b0;
            acc_plan = i2cm_pkg::plan_entry(i_item.mode, 3'd0, i_item.device_address,
                                            i_item.register_address, i_item.tx_byte);
            n_step  = 3'd0;
            n_phase = '0;
            n_bit   = 4'd0;
            n_state = i2cm_pkg::seg_first_state(acc_plan.kind);
            if (acc_plan.kind == i2cm_pkg::SEG_TX) begin
                n_shift = acc_plan.data;
            end else if (acc_plan.kind == i2cm_pkg::SEG_RX) begin
                n_shift = 8'd0;
            end
        end

        if (n_state != i2cm_pkg::ST_IDLE) begin
            busy = 1'b1;
            case (n_state)
                i2cm_pkg::ST_S_PRE: begin scl = 1'b0; sda = 1'b1; end
                i2cm_pkg::ST_S_H1, i2cm_pkg::ST_S_H2: begin scl = 1'b1; sda = 1'b1; end
                i2cm_pkg::ST_S_L1, i2cm_pkg::ST_S_L2: begin scl = 1'b1; sda = 1'b0; end
                i2cm_pkg::ST_P_L: begin scl = 1'b0; sda = 1'b0; end
                i2cm_pkg::ST_P_H1, i2cm_pkg::ST_P_H2: begin scl = 1'b1; sda = 1'b0; end
                i2cm_pkg::ST_P_R1, i2cm_pkg::ST_P_R2: begin scl = 1'b1; sda = 1'b1; end
                i2cm_pkg::ST_T_LO, i2cm_pkg::ST_T_HI: begin
                    scl = (n_state == i2cm_pkg::ST_T_HI);
                    sda = (n_bit < 4'd8) ? n_shift[7] : 1'b1;
                end
                i2cm_pkg::ST_R_LO, i2cm_pkg::ST_R_HI: begin
                    scl = (n_state == i2cm_pkg::ST_R_HI);
                    // answer slot: ACK only for a plain read that asked for it
                    sda = (n_bit < 4'd8) ? 1'b1
                        : !(n_mode == i2cm_pkg::MODE_READ && n_ack);
                end
                default: begin scl = 1'b1; sda = 1'b1; end
            endcase
            n_line_scl = scl;
            n_line_sda = sda;

            if (n_state == i2cm_pkg::ST_POLL) begin
                if (!i_item.sda_sampled) begin
                    seg_end = 1'b1;
                end else begin
                    n_wait = n_wait + 1'b1;
                    if (n_wait >= w_limit) begin
                        n_err = 1'b1;
                        n_stop_ins = 1'b1;
                        n_phase = '0;
                        n_bit = 4'd0;
                        n_state = i2cm_pkg::ST_P_L;
                    end
                end
            end else if ({1'b0, n_phase} + 1'b1 < {1'b0, w_plen}) begin
                n_phase = n_phase + 1'b1;
            end else begin
                n_phase = '0;
                case (n_state)
                    i2cm_pkg::ST_S_PRE: n_state = i2cm_pkg::ST_S_H1;
                    i2cm_pkg::ST_S_H1:  n_state = i2cm_pkg::ST_S_H2;
                    i2cm_pkg::ST_S_H2:  n_state = i2cm_pkg::ST_S_L1;
                    i2cm_pkg::ST_S_L1:  n_state = i2cm_pkg::ST_S_L2;
                    i2cm_pkg::ST_S_L2:  seg_end = 1'b1;
                    i2cm_pkg::ST_P_L:   n_state = i2cm_pkg::ST_P_H1;
                    i2cm_pkg::ST_P_H1:  n_state = i2cm_pkg::ST_P_H2;
                    i2cm_pkg::ST_P_H2:  n_state = i2cm_pkg::ST_P_R1;
                    i2cm_pkg::ST_P_R1:  n_state = i2cm_pkg::ST_P_R2;
                    i2cm_pkg::ST_P_R2: begin
                        seg_end = 1'b1;
                        was_stop = 1'b1;
                    end
                    i2cm_pkg::ST_T_LO:  n_state = i2cm_pkg::ST_T_HI;
                    i2cm_pkg::ST_T_HI: begin
                        if (n_bit < 4'd8) begin
                            n_shift = {n_shift[6:0], 1'b0};
                            n_bit = n_bit + 1'b1;
                            n_state = i2cm_pkg::ST_T_LO;
                        end else begin
                            n_wait = '0;
                            n_state = i2cm_pkg::ST_POLL;
                        end
                    end
                    i2cm_pkg::ST_R_LO:  n_state = i2cm_pkg::ST_R_HI;
                    i2cm_pkg::ST_R_HI: begin
                        if (n_bit < 4'd8) begin
                            rx_shift = {n_shift[6:0], i_item.sda_sampled};
                            n_shift = rx_shift;
                            if (n_bit == 4'd7) begin
                                n_rx = rx_shift;
                            end
                            n_bit = n_bit + 1'b1;
                            n_state = i2cm_pkg::ST_R_LO;
                        end else begin
                            seg_end = 1'b1;
                        end
                    end
                    default: n_state = i2cm_pkg::ST_IDLE;
                endcase
            end
        end

        if (seg_end) begin
            idx = n_step + 1'b1;
            after_stop = was_stop;
            if (was_stop && n_stop_ins) begin
                // stop forced by an ACK timeout: only a register write goes on
                n_stop_ins = 1'b0;
                fin = (n_mode != i2cm_pkg::MODE_REG_WRITE);
            end
            if (!fin) begin
                nxt_plan = i2cm_pkg::plan_entry(n_mode, idx, n_dev, n_reg, n_data);
                if (nxt_plan.kind == i2cm_pkg::SEG_NONE) begin
                    fin = 1'b1;
                end else begin
                    n_step  = idx;
                    n_phase = '0;
                    n_bit   = 4'd0;
                    n_state = i2cm_pkg::seg_first_state(nxt_plan.kind);
                    if (nxt_plan.kind == i2cm_pkg::SEG_TX) begin
                        n_shift = nxt_plan.data;
                    end else if (nxt_plan.kind == i2cm_pkg::SEG_RX) begin
                        n_shift = 8'd0;
                    end
                end
            end
            if (fin) begin
                n_state = i2cm_pkg::ST_IDLE;
                done = 1'b1;
                if (after_stop) begin
                    n_line_scl = 1'b1;
                    n_line_sda = 1'b1;
                end else begin
                    n_line_scl = 1'b0;
                end
            end
        end

        o_res.scl_level   = scl;
        o_res.sda_release = sda;
        o_res.busy_res    = busy;
        o_res.done_res    = done;
        o_res.rx_byte     = n_rx;
        o_res.ack_error   = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= i2cm_pkg::ST_IDLE;
            r_phase    <= '0;
            r_bit      <= 4'd0;
            r_shift    <= 8'd0;
            r_step     <= 3'd0;
            r_wait     <= '0;
            r_err      <= 1'b0;
            r_rx       <= 8'd0;
            r_mode     <= 3'd0;
            r_dev      <= 8'd0;
            r_reg      <= 8'd0;
            r_data     <= 8'd0;
            r_ack      <= 1'b0;
            r_stop_ins <= 1'b0;
            r_line_scl <= 1'b1;
            r_line_sda <= 1'b1;
        end else if (i_step) begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_step     <= n_step;
            r_wait     <= n_wait;
            r_err      <= n_err;
            r_rx       <= n_rx;
            r_mode     <= n_mode;
            r_dev      <= n_dev;
            r_reg      <= n_reg;
            r_data     <= n_data;
            r_ack      <= n_ack;
            r_stop_ins <= n_stop_ins;
            r_line_scl <= n_line_scl;
            r_line_sda <= n_line_sda;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.done_res |-> o_res.busy_res)
        else $error("done without busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.done_res |=> r_state == i2cm_pkg::ST_IDLE)
        else $error("sequencer not idle after done");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == i2cm_pkg::ST_IDLE |-> r_phase == '0)
        else $error("phase counter running while idle");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= 4'd8)
        else $error("bit counter out of range");

    a_forced_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stop_ins |-> (r_state == i2cm_pkg::ST_P_L || r_state == i2cm_pkg::ST_P_H1 ||
                        r_state == i2cm_pkg::ST_P_H2 || r_state == i2cm_pkg::ST_P_R1 ||
                        r_state == i2cm_pkg::ST_P_R2))
        else $error("forced stop flag outside a stop segment");
`endif

endmodule

// ===== hw/rtl/i2c_master_register_access.sv =====
// I2C master register access: one tick word in, one bus-level word out every unstalled clock.
// Each input word is one tick of the bus time base; the block returns exactly one output
// word per input word, with SCL, SDA drive, busy, done, last received byte and ACK error.
// A word is taken every clock cycle unless the output stalls. Each accepted word passes
// from the input register through the combinational sequencer step into the output
// register. While the output is stalled the input register holds its word and the input
// side stops accepting.
// Configuration writes are expected while no command runs and no word is in flight.
module i2c_master_register_access (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [i2cm_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [15:0]                       i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] tx_byte, [8] send_ack, [16:9] device_address, [24:17] register_address,
    // [25] sda_sampled, [31:26] zero
    input  logic [31:0]                       s_axis_tdata,
    // [0] command_valid, [3:1] mode
    input  logic [3:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] scl_level, [1] sda_release, [2] busy_res, [3] done_res, [11:4] rx_byte,
    // [12] ack_error, [15:13] zero
    output logic [15:0]                       m_axis_tdata
);

    logic [i2cm_pkg::PHASE_BITS-1:0] r_phase_ticks;
    logic [i2cm_pkg::POLL_BITS-1:0]  r_ack_polls;
    logic                            r_in_valid;
    i2cm_pkg::t_item                 r_in;
    logic                            r_out_valid;
    i2cm_pkg::t_result               r_out;
    i2cm_pkg::t_result               w_res;
    logic                            w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cm_pkg::PHASE_TICKS_RST;
            r_ack_polls   <= i2cm_pkg::ACK_POLLS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cm_pkg::CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_wdata;
                i2cm_pkg::CFG_ACK_POLLS:   r_ack_polls <= i_cfg_wdata[i2cm_pkg::POLL_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_adv = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.command_valid    <= s_axis_tuser[0];
            r_in.mode             <= s_axis_tuser[3:1];
            r_in.tx_byte          <= s_axis_tdata[7:0];
            r_in.send_ack         <= s_axis_tdata[8];
            r_in.device_address   <= s_axis_tdata[16:9];
            r_in.register_address <= s_axis_tdata[24:17];
            r_in.sda_sampled      <= s_axis_tdata[25];
        end
    end

    i2cm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_item       (r_in),
        .i_phase_ticks(r_phase_ticks),
        .i_ack_polls  (r_ack_polls),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.ack_error, r_out.rx_byte, r_out.done_res,
                            r_out.busy_res, r_out.sda_release, r_out.scl_level};

endmodule
